FILE: sv/trma_pkg.sv
// package for the typed register moving average unit
// holds data widths, register type codes, config register indexes and the
// sequencer state type; no dependencies

package trma_pkg;

  // sample and value width
  localparam int DATA_W = 32;

  // default window slot count; the window holds one sample fewer than this
  localparam int WINDOW_SLOTS_DEF = 8;

  // one quotient bit per divider step
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // config port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_TYPE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_ENABLE = 2'd1;

  // register type codes
  localparam int TYPE_W = 3;

  localparam logic [TYPE_W-1:0] VT_BIT     = 3'd0;
  localparam logic [TYPE_W-1:0] VT_BYTE    = 3'd1;
  localparam logic [TYPE_W-1:0] VT_HALF    = 3'd2;
  localparam logic [TYPE_W-1:0] VT_WORD    = 3'd3;
  localparam logic [TYPE_W-1:0] VT_BITMAP  = 3'd4;
  localparam logic [TYPE_W-1:0] VT_INVALID = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLACE,
    ST_DIV,
    ST_FIN
  } trma_state_t;

  // mirror of a value for a given type: bit and byte truncated to 8 bits, half to 16, both sign-extended;
  function automatic logic [DATA_W:0] mirror_of(input logic [TYPE_W-1:0] vtype,
                                                input logic [DATA_W-1:0] value);
    logic [DATA_W:0] res;
    res = '0;
    unique case (vtype) inside
      VT_BIT, VT_BYTE: res = {1'b1, {(DATA_W-8){value[7]}}, value[7:0]};
      VT_HALF:         res = {1'b1, {(DATA_W-16){value[15]}}, value[15:0]};
      VT_WORD, VT_BITMAP: res = {1'b1, value};
      default:         res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: sv/typed_register_moving_average_unit.sv
// flow: bit and bitmap types go from input word to result word through the
// finish state; averaging types first pass a window replace step once the
// window is full, then the 32-step shared restoring divider (one quotient bit
// a cycle); a new input word is taken only after the last result is registered
// reset: rst is synchronous and active high; type resets to invalid, mirror
// off, window empty (fill count, so the window memory needs no clearing pass)

module typed_register_moving_average_unit
  import trma_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_W-1:0]      sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_W-1:0]      current_value,
  output logic signed [DATA_W-1:0]      mirror_value,
  output logic                          mirror_valid
);

  // number of samples held in the window
  localparam int HELD_MAX = WINDOW_SLOTS - 1;
  // held count must reach HELD_MAX
  localparam int CW = $clog2(WINDOW_SLOTS);
  // slot address width
  localparam int AW = (HELD_MAX > 1) ? $clog2(HELD_MAX) : 1;

  localparam logic [CW-1:0] HELD_FULL = CW'(HELD_MAX);
  localparam logic [AW-1:0] SLOT_LAST = AW'(HELD_MAX - 1);

  // config registers
  logic [TYPE_W-1:0]   value_type;
  logic                mirror_enable;

  // window state
  logic [CW-1:0]       held_count;
  logic [DATA_W-1:0]   running_sum;
  logic [AW-1:0]       oldest_slot;
  logic [DATA_W-1:0]   value_reg;

  // window memory, one write and one registered read a cycle
  logic [DATA_W-1:0]   win_mem [HELD_MAX];
  logic [DATA_W-1:0]   rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;

  // sequencer and divider
  trma_state_t         state;
  trma_state_t         state_next;
  logic [DATA_W-1:0]   sample_hold;
  logic [DATA_W-1:0]   quot;
  logic [CW-1:0]       rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                in_acc;
  logic                cfg_acc;
  logic                averaging;
  logic                win_full;
  logic                out_free;
  logic [DATA_W-1:0]   sum_fill;
  logic [DATA_W-1:0]   sum_replace;
  logic [CW:0]         rem_shift;
  logic [CW:0]         rem_diff;
  logic                q_bit;
  logic [CW-1:0]       rem_new;
  logic [DATA_W:0]     mirror_res;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_acc    = in_valid & in_ready;

  // bit and bitmap take the sample as is, everything else averages
  assign averaging = !((value_type == VT_BIT) || (value_type == VT_BITMAP));
  assign win_full  = (held_count == HELD_FULL);
  // output register can take a new word
  assign out_free  = !out_valid || out_ready;

  // running sum updates, both wrap modulo 2^32
  assign sum_fill    = running_sum + sample;
  assign sum_replace = running_sum - rd_data + sample_hold;

  // one restoring divider step: shift in the next dividend bit, try subtract
  assign rem_shift = {rem, quot[DATA_W-1]};
  assign rem_diff  = rem_shift - {1'b0, held_count};
  assign q_bit     = (rem_shift >= {1'b0, held_count});
  assign rem_new   = q_bit ? rem_diff[CW-1:0] : rem_shift[CW-1:0];

  assign mirror_res = mirror_of(value_type, value_reg);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (!averaging) begin
            state_next = ST_FIN;
          end else if (win_full) begin
            state_next = ST_REPLACE;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_REPLACE: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = oldest_slot;
    mem_wdata = sample_hold;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // filling: oldest slot stays at zero, so the next slot is the count
        mem_we    = in_valid && averaging && !win_full;
        mem_waddr = held_count[AW-1:0];
        mem_wdata = sample;
      end
      ST_REPLACE: begin
        mem_we = 1'b1;
      end
      ST_DIV, ST_FIN: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    // oldest sample is read ahead, ready when a full-window word arrives
    rd_data <= win_mem[oldest_slot];
  end

  // config registers and window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      value_type    <= VT_INVALID;
      mirror_enable <= 1'b0;
      held_count    <= '0;
      running_sum   <= '0;
      oldest_slot   <= '0;
      value_reg     <= '0;
    end else if (cfg_acc) begin
      // type write empties the window
      if (cfg_index == CFG_VALUE_TYPE) begin
        value_type  <= cfg_data[TYPE_W-1:0];
        held_count  <= '0;
        running_sum <= '0;
        oldest_slot <= '0;
        value_reg   <= '0;
      end else if (cfg_index == CFG_MIRROR_ENABLE) begin
        mirror_enable <= cfg_data[0];
      end
    end else begin
      if (in_acc) begin
        if (!averaging) begin
          value_reg <= sample;
        end else if (!win_full) begin
          held_count  <= held_count + 1'b1;
          running_sum <= sum_fill;
        end
      end
      if (state == ST_REPLACE) begin
        running_sum <= sum_replace;
        oldest_slot <= (oldest_slot == SLOT_LAST) ? '0 : oldest_slot + 1'b1;
      end
      // last divider step lands the quotient
      if ((state == ST_DIV) && (div_cnt == '0)) begin
        value_reg <= {quot[DATA_W-2:0], q_bit};
      end
    end
  end

  // divider datapath and sample hold
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_hold <= sample;
      quot        <= sum_fill;
      rem         <= '0;
      div_cnt     <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (state == ST_REPLACE) begin
      quot <= sum_replace;
    end else if (state == ST_DIV) begin
      quot    <= {quot[DATA_W-2:0], q_bit};
      rem     <= rem_new;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      current_value <= value_reg;
      mirror_value  <= mirror_enable ? mirror_res[DATA_W-1:0] : '0;
      mirror_valid  <= mirror_enable & mirror_res[DATA_W];
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the window size
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= HELD_FULL)
    else $error("held count beyond window size");

  // the oldest slot only moves once the window is full
  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_slot != '0) |-> win_full)
    else $error("oldest slot moved before window filled");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < held_count))
    else $error("divider remainder not below held count");

  // no new word is taken right after one was accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input accepted while busy");

  // averaging words always divide by a nonzero count
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (held_count != '0))
    else $error("divide by zero held count");
`endif

endmodule
